@@ rtl/dfl_pkg.sv @@
// Shared types, constants and the microcode program of the DDS frequency-lock PI step.
// No dependencies; every other file of the block imports this package.
package dfl_pkg;

   // field widths
   localparam int FREQ_W   = 28;
   localparam int ERR_W    = 29;
   localparam int GAIN_W   = 16;
   localparam int WPH_W    = 24;
   localparam int INTEG_W  = 15;
   localparam int STEP_W   = 14;
   localparam int MUL_A_W  = 17;
   localparam int MUL_B_W  = 28;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W    = 39;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 28;
   localparam int UPC_W    = 5;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 96;

   // fixed constants of the control law
   localparam logic [FREQ_W-1:0]       FREQ_RESET   = 28'd10240000;  // 40 kHz in Q20.8
   localparam logic signed [ERR_W-1:0] DEAD_ZONE_Q8 = 29'sd512;      // 2 Hz
   localparam logic signed [SUM_W-1:0] INTEG_LIMIT  = 39'sd12800;    // 50 Hz
   localparam logic signed [SUM_W-1:0] STEP_LIMIT   = 39'sd5120;     // 20 Hz
   localparam logic [1:0]              REG_SELECT   = 2'b01;
   localparam int                      HALF_W       = 14;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_EXT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_GEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOCK_TOL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WORD_PER_HZ = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_START_WORD = 3'd6;

   // register reset values
   localparam logic [GAIN_W-1:0] ALPHA_EXT_RST  = 16'd58982;
   localparam logic [GAIN_W-1:0] ALPHA_GEN_RST  = 16'd32768;
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd128;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;
   localparam logic [GAIN_W-1:0] LOCK_TOL_RST   = 16'd256;
   localparam logic [WPH_W-1:0]  WPH_RST        = 24'd703687;
   localparam logic [FREQ_W-1:0] START_WORD_RST = 28'd0;

   typedef struct packed {
      logic [GAIN_W-1:0] alpha_ext;
      logic [GAIN_W-1:0] alpha_gen;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] lock_tol;
      logic [WPH_W-1:0]  word_per_hz;
      logic [FREQ_W-1:0] start_word;
   } dfl_cfg_type;

   // datapath operations, one per microcode step
   typedef enum logic [4:0] {
      OP_NOP,
      OP_START,
      OP_SEED,
      OP_MUL_EXT_OLD,
      OP_MUL_EXT_NEW,
      OP_STORE_EXT,
      OP_MUL_GEN_OLD,
      OP_MUL_GEN_NEW,
      OP_STORE_GEN,
      OP_ERROR,
      OP_MUL_KI,
      OP_INTEG,
      OP_MUL_KP,
      OP_STEP,
      OP_MUL_WORD,
      OP_WORD,
      OP_DONE
   } dfl_op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NOT_VALID,
      COND_SEEDED,
      COND_IN_TOL
   } dfl_cond_type;

   typedef struct packed {
      dfl_op_type         op;
      dfl_cond_type       cond;
      logic [UPC_W-1:0]   target;
   } dfl_uword_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic frame_valid;
      logic seeded;
      logic in_tol;
      logic out_free;
   } dfl_status_type;

   // program addresses used as jump targets
   localparam logic [UPC_W-1:0] UA_START = 5'd0;
   localparam logic [UPC_W-1:0] UA_SMOOTH = 5'd3;
   localparam logic [UPC_W-1:0] UA_ERROR = 5'd9;
   localparam logic [UPC_W-1:0] UA_DONE  = 5'd16;

   function automatic dfl_uword_type dfl_uw(input dfl_op_type op, input dfl_cond_type cond,
                                            input logic [UPC_W-1:0] target);
      dfl_uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // microcode program
   function automatic dfl_uword_type dfl_ucode(input logic [UPC_W-1:0] addr);
      dfl_uword_type w;
      unique case (addr)
         5'd0:    w = dfl_uw(OP_START,       COND_NOT_VALID, UA_DONE);
         5'd1:    w = dfl_uw(OP_NOP,         COND_SEEDED,    UA_SMOOTH);
         5'd2:    w = dfl_uw(OP_SEED,        COND_ALWAYS,    UA_ERROR);
         5'd3:    w = dfl_uw(OP_MUL_EXT_OLD, COND_NEXT,      UA_START);
         5'd4:    w = dfl_uw(OP_MUL_EXT_NEW, COND_NEXT,      UA_START);
         5'd5:    w = dfl_uw(OP_STORE_EXT,   COND_NEXT,      UA_START);
         5'd6:    w = dfl_uw(OP_MUL_GEN_OLD, COND_NEXT,      UA_START);
         5'd7:    w = dfl_uw(OP_MUL_GEN_NEW, COND_NEXT,      UA_START);
         5'd8:    w = dfl_uw(OP_STORE_GEN,   COND_NEXT,      UA_START);
         5'd9:    w = dfl_uw(OP_ERROR,       COND_NEXT,      UA_START);
         5'd10:   w = dfl_uw(OP_MUL_KI,      COND_NEXT,      UA_START);
         5'd11:   w = dfl_uw(OP_INTEG,       COND_NEXT,      UA_START);
         5'd12:   w = dfl_uw(OP_MUL_KP,      COND_NEXT,      UA_START);
         5'd13:   w = dfl_uw(OP_STEP,        COND_IN_TOL,    UA_DONE);
         5'd14:   w = dfl_uw(OP_MUL_WORD,    COND_NEXT,      UA_START);
         5'd15:   w = dfl_uw(OP_WORD,        COND_NEXT,      UA_START);
         default: w = dfl_uw(OP_DONE,        COND_NEXT,      UA_START);
      endcase
      return w;
   endfunction

endpackage

@@ rtl/dfl_csr.sv @@
// Configuration registers of the frequency-lock step, written through the csr_ channel.
// Depends on dfl_pkg.
module dfl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dfl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dfl_pkg::CSR_DAT_W-1:0] csr_data,
   output dfl_pkg::dfl_cfg_type          cfg,
   output logic                          load_word
);
   import dfl_pkg::*;

   dfl_cfg_type cfg_ff, cfg_in;
   logic        load_word_ff, load_word_in;
   logic        wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in       = cfg_ff;
      load_word_in = 1'b0;
      if (wr_en) begin
         unique case (csr_index)
            REG_ALPHA_EXT:   cfg_in.alpha_ext   = csr_data[GAIN_W-1:0];
            REG_ALPHA_GEN:   cfg_in.alpha_gen   = csr_data[GAIN_W-1:0];
            REG_PROP_GAIN:   cfg_in.prop_gain   = csr_data[GAIN_W-1:0];
            REG_INTEG_GAIN:  cfg_in.integ_gain  = csr_data[GAIN_W-1:0];
            REG_LOCK_TOL:    cfg_in.lock_tol    = csr_data[GAIN_W-1:0];
            REG_WORD_PER_HZ: cfg_in.word_per_hz = csr_data[WPH_W-1:0];
            REG_START_WORD: begin
               cfg_in.start_word = csr_data[FREQ_W-1:0];
               load_word_in      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // the current word is loaded in the cycle after the write, from the updated register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_ext   <= ALPHA_EXT_RST;
         cfg_ff.alpha_gen   <= ALPHA_GEN_RST;
         cfg_ff.prop_gain   <= PROP_GAIN_RST;
         cfg_ff.integ_gain  <= INTEG_GAIN_RST;
         cfg_ff.lock_tol    <= LOCK_TOL_RST;
         cfg_ff.word_per_hz <= WPH_RST;
         cfg_ff.start_word  <= START_WORD_RST;
         load_word_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         load_word_ff <= load_word_in;
      end
   end

   assign cfg       = cfg_ff;
   assign load_word = load_word_ff;

endmodule

@@ rtl/dfl_sequencer.sv @@
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on dfl_pkg for the program and the control word types.
module dfl_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  dfl_pkg::dfl_status_type status,
   output dfl_pkg::dfl_op_type     exec_op
);
   import dfl_pkg::*;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   dfl_uword_type    uword;
   logic             take_jump;
   logic             running;
   logic             hold;

   assign uword      = dfl_ucode(pc_ff);
   assign running    = (state_ff == SEQ_RUN);
   assign req_tready = (state_ff == SEQ_IDLE);
   // the final step waits while the previous result is still on the port
   assign hold       = (uword.op == OP_DONE) && !status.out_free;
   assign exec_op    = (running && !hold) ? uword.op : OP_NOP;

   // jump condition decode
   always_comb begin
      unique case (uword.cond)
         COND_NEXT:      take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_NOT_VALID: take_jump = !status.frame_valid;
         COND_SEEDED:    take_jump = status.seeded;
         COND_IN_TOL:    take_jump = status.in_tol;
         default:        take_jump = 1'b0;
      endcase
   end

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_tvalid) begin
               state_in = SEQ_RUN;
               pc_in    = UA_START;
            end
         end
         SEQ_RUN: begin
            if (uword.op == OP_DONE) begin
               if (!hold) state_in = SEQ_IDLE;
            end else if (take_jump) begin
               pc_in = uword.target;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= UA_START;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   // a new request always starts the program at its first step
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (running && pc_ff == UA_START))
      else $error("sequencer did not start at the first step");

   // the step counter never leaves the program
   assert property (@(posedge clock) disable iff (reset)
      running |-> (pc_ff <= UA_DONE))
      else $error("step counter outside the program");

endmodule

@@ rtl/dfl_datapath.sv @@
// Datapath of the frequency-lock step: smoother, integrator and tuning word state,
// one shared multiplier and the result register. Depends on dfl_pkg.
module dfl_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_accept,
   input  logic [dfl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  dfl_pkg::dfl_cfg_type           cfg,
   input  logic                           load_word,
   input  dfl_pkg::dfl_op_type            exec_op,
   output dfl_pkg::dfl_status_type        status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dfl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import dfl_pkg::*;

   function automatic logic signed [SUM_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                         input logic signed [SUM_W-1:0] lim);
      logic signed [SUM_W-1:0] r;
      if (v > lim)       r = lim;
      else if (v < -lim) r = -lim;
      else               r = v;
      return r;
   endfunction

   // captured request
   logic [FREQ_W-1:0] ext_ff, gen_ff;
   logic              fv_ff;
   // persistent state
   logic [FREQ_W-1:0]         sext_ff, sext_in, sgen_ff, sgen_in;
   logic                      seeded_ff, seeded_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic [FREQ_W-1:0]         word_ff, word_in;
   // working registers
   logic [PROD_W-1:0]         acc_ff, acc_in, prod_ff, prod_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [FREQ_W-1:0]         mag_e_ff, mag_e_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;
   logic                      written_ff, written_in;
   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;

   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [PROD_W:0]         smooth_sum;
   logic signed [ERR_W-1:0] diff;
   logic signed [ERR_W-1:0] err_dz;
   logic [PROD_W-1:0]       prod_rnd;
   logic signed [SUM_W-1:0] gain_term;
   logic signed [SUM_W-1:0] integ_sum;
   logic signed [SUM_W-1:0] step_sum;
   logic signed [SUM_W-1:0] integ_clamped;
   logic signed [SUM_W-1:0] step_clamped;
   logic signed [STEP_W-1:0] step_abs;
   logic [STEP_W-2:0]       mag_step;
   logic [ERR_W-1:0]        err_abs;
   logic [PROD_W-25:0]      delta;

   // operand select for the shared multiplier
   always_comb begin
      unique case (exec_op)
         OP_MUL_EXT_OLD: begin
            mul_a = {1'b0, cfg.alpha_ext};
            mul_b = sext_ff;
         end
         OP_MUL_EXT_NEW: begin
            mul_a = 17'h10000 - {1'b0, cfg.alpha_ext};
            mul_b = ext_ff;
         end
         OP_MUL_GEN_OLD: begin
            mul_a = {1'b0, cfg.alpha_gen};
            mul_b = sgen_ff;
         end
         OP_MUL_GEN_NEW: begin
            mul_a = 17'h10000 - {1'b0, cfg.alpha_gen};
            mul_b = gen_ff;
         end
         OP_MUL_KI: begin
            mul_a = {1'b0, cfg.integ_gain};
            mul_b = mag_e_ff;
         end
         OP_MUL_KP: begin
            mul_a = {1'b0, cfg.prop_gain};
            mul_b = mag_e_ff;
         end
         OP_MUL_WORD: begin
            mul_a = {{(MUL_A_W-STEP_W+1){1'b0}}, mag_step};
            mul_b = {{(MUL_B_W-WPH_W){1'b0}}, cfg.word_per_hz};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

   // smoother: weighted sum rounded back to Q20.8
   assign smooth_sum = {1'b0, acc_ff} + {1'b0, prod_ff} + (PROD_W+1)'(32768);

   // error with dead zone
   assign diff   = $signed({1'b0, sext_ff}) - $signed({1'b0, sgen_ff});
   assign err_dz = (diff > -DEAD_ZONE_Q8 && diff < DEAD_ZONE_Q8) ? '0 : diff;
   assign err_abs = err_dz[ERR_W-1] ? -err_dz : err_dz;

   // gain product rounded to Q.8, tie away from zero, sign of the error applied
   assign prod_rnd  = prod_ff + PROD_W'(128);
   assign gain_term = err_ff[ERR_W-1] ? -$signed({2'b00, prod_rnd[PROD_W-1:8]})
                                      :  $signed({2'b00, prod_rnd[PROD_W-1:8]});
   assign integ_sum = gain_term + SUM_W'(integ_ff);
   assign step_sum  = gain_term + SUM_W'(integ_ff);
   assign integ_clamped = clamp_sym(integ_sum, INTEG_LIMIT);
   assign step_clamped  = clamp_sym(step_sum, STEP_LIMIT);

   assign step_abs = step_ff[STEP_W-1] ? -step_ff : step_ff;
   assign mag_step = step_abs[STEP_W-2:0];
   assign delta    = prod_ff[PROD_W-1:24];

   // per-step register updates
   always_comb begin
      sext_in    = sext_ff;
      sgen_in    = sgen_ff;
      seeded_in  = seeded_ff;
      integ_in   = integ_ff;
      word_in    = word_ff;
      acc_in     = acc_ff;
      err_in     = err_ff;
      mag_e_in   = mag_e_ff;
      step_in    = step_ff;
      written_in = written_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (exec_op) inside
         OP_START: begin
            err_in     = '0;
            written_in = 1'b0;
         end
         OP_SEED: begin
            sext_in   = ext_ff;
            sgen_in   = gen_ff;
            seeded_in = 1'b1;
         end
         OP_MUL_EXT_NEW, OP_MUL_GEN_NEW: acc_in = prod_ff;
         OP_STORE_EXT:   sext_in = smooth_sum[FREQ_W+15:16];
         OP_STORE_GEN:   sgen_in = smooth_sum[FREQ_W+15:16];
         OP_ERROR: begin
            err_in   = err_dz;
            mag_e_in = err_abs[FREQ_W-1:0];
            // integrator clears when the error turns against it
            if ((integ_ff > 0 && err_dz < 0) || (integ_ff < 0 && err_dz > 0)) integ_in = '0;
         end
         OP_INTEG:  integ_in = integ_clamped[INTEG_W-1:0];
         OP_STEP:   step_in  = step_clamped[STEP_W-1:0];
         OP_WORD: begin
            if (step_ff[STEP_W-1]) word_in = word_ff - FREQ_W'(delta);
            else                   word_in = word_ff + FREQ_W'(delta);
            written_in = 1'b1;
         end
         OP_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_user_in  = written_ff;
            rsp_data_in  = {7'b0, err_ff,
                            REG_SELECT, word_ff[FREQ_W-1:HALF_W],
                            REG_SELECT, word_ff[HALF_W-1:0],
                            word_ff};
         end
         default: ;
      endcase
      if (load_word) word_in = cfg.start_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sext_ff      <= FREQ_RESET;
         sgen_ff      <= FREQ_RESET;
         seeded_ff    <= 1'b0;
         integ_ff     <= '0;
         word_ff      <= START_WORD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         sext_ff      <= sext_in;
         sgen_ff      <= sgen_in;
         seeded_ff    <= seeded_in;
         integ_ff     <= integ_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ext_ff <= req_tdata[FREQ_W-1:0];
         gen_ff <= req_tdata[2*FREQ_W-1:FREQ_W];
         fv_ff  <= req_tuser;
      end
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      err_ff      <= err_in;
      mag_e_ff    <= mag_e_in;
      step_ff     <= step_in;
      written_ff  <= written_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign status.frame_valid = fv_ff;
   assign status.seeded      = seeded_ff;
   assign status.in_tol      = (mag_e_ff <= FREQ_W'(cfg.lock_tol));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // integrator stays inside its clamp
   assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(integ_ff) <= INTEG_LIMIT) && (SUM_W'(integ_ff) >= -INTEG_LIMIT))
      else $error("integrator beyond its limit");

   // a word update always follows a step that is inside its clamp
   assert property (@(posedge clock) disable iff (reset)
      (exec_op == OP_WORD) |-> ((SUM_W'(step_ff) <= STEP_LIMIT) &&
                                (SUM_W'(step_ff) >= -STEP_LIMIT)))
      else $error("step beyond its limit at word update");

endmodule

@@ rtl/dds_frequency_lock_pi_step.sv @@
// Top level of the DDS frequency-lock PI step for one channel.
// Depends on dfl_pkg, dfl_csr, dfl_sequencer and dfl_datapath.
//
// One request carries one frame's measured external and DDS frequencies plus a
// frame-valid flag; one response carries the tuning word after the step, its two
// 16-bit frequency register words, the dead-zoned smoothed error and a flag that
// says the word was updated. A microcoded program steps a single shared 17x28
// multiplier through smoothing, integral, proportional and word-delta products,
// so the program length sets the rate; no new request is taken until the program
// ends. A frame within tolerance skips the word steps, the first valid frame
// seeds the smoothers instead of smoothing them, an invalid frame goes straight
// to the final step, and the final step waits while the previous response waits
// on rsp_tready. Configuration writes are taken in every cycle and
// must be made while no request is in flight; writing the start tuning word also
// loads the current word. Two channels need two instances.
module dds_frequency_lock_pi_step (
   input  logic                           clock,
   input  logic                           reset,
   // request: frame measurements
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dfl_pkg::REQ_DATA_W-1:0] req_tdata,   // measured_external[27:0], measured_generated[55:28]
   input  logic                           req_tuser,   // frame_valid
   // response: step result
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dfl_pkg::RSP_DATA_W-1:0] rsp_tdata,   // tuning_word[27:0], low_reg_word[43:28],
                                                       // high_reg_word[59:44], freq_error[88:60], zeros
   output logic                           rsp_tuser,   // word_written
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfl_pkg::CSR_DAT_W-1:0]  csr_data
);
   import dfl_pkg::*;

   dfl_cfg_type    cfg;
   logic           load_word;
   dfl_status_type status;
   dfl_op_type     exec_op;
   logic           req_accept;

   assign req_accept = req_tvalid && req_tready;

   dfl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .load_word (load_word)
   );

   dfl_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .exec_op    (exec_op)
   );

   dfl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .load_word  (load_word),
      .exec_op    (exec_op),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the DDS frequency-lock PI step (one channel).
// Needs only dfl_pkg and the dds_frequency_lock_pi_step RTL; a built-in predictor
// tracks smoothers, integrator and tuning word and checks every response.
`timescale 1ns / 100ps

module tb_top;
   import dfl_pkg::*;

   localparam logic [FREQ_W-1:0]    FREQ_MAX     = '1;
   localparam logic [FREQ_W-1:0]    SMOOTH_RESET = 28'd10240000;  // 40 kHz, Q20.8
   localparam longint               DEAD_BAND    = 512;           // 2 Hz
   localparam longint               INTEG_CLAMP  = 12800;         // 50 Hz
   localparam longint               STEP_CLAMP   = 5120;          // 20 Hz
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED   = 3'd7;          // no register here
   localparam int                   PHASES       = 8;
   localparam int                   PHASE_FRAMES = 108;
   localparam int                   CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [FREQ_W-1:0] tuning_word;
      logic              word_written;
      logic [15:0]       low_reg_word;
      logic [15:0]       high_reg_word;
      logic [ERR_W-1:0]  freq_error;
   } lock_result_type;

   typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [FREQ_W-1:0]  ext;
      logic [FREQ_W-1:0]  gen;
      logic               valid;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] value;
      bit                 typed;
      lock_result_type    want;
   } stim_row_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // measured_external, measured_generated
   logic                  req_tuser  = 1'b0; // frame_valid
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // tuning_word, low_reg_word, high_reg_word, freq_error
   logic                  rsp_tuser;  // word_written
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DAT_W-1:0]  csr_data   = '0;

   // predictor state
   dfl_cfg_type       lock_cfg;
   logic [FREQ_W-1:0] smoothed_ext, smoothed_gen, tracked_word;
   bit                smoothers_seeded;
   longint            integ_acc;

   lock_result_type pending_lock_results[$];
   stim_row_type    directed_rows[$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left  = 0;
   bit              req_held    = 0;
   ready_mode_type  ready_mode  = RDY_ALWAYS;
   int              ready_stretch = 0;

   dds_frequency_lock_pi_step DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [FREQ_W-1:0] smooth_freq(input logic [FREQ_W-1:0] prev,
                                                     input logic [FREQ_W-1:0] meas,
                                                     input logic [GAIN_W-1:0] weight);
      longint unsigned acc;
      acc = longint'(weight) * prev + (65536 - longint'(weight)) * meas + 32768;
      return acc[43:16];
   endfunction

   // Q8.8 gain times Q.8 error, back to Q.8, ties away from zero
   function automatic longint round_gain(input logic [GAIN_W-1:0] gain, input longint err);
      longint mag, r;
      mag = (err < 0) ? -err : err;
      r   = (longint'(gain) * mag + 128) >>> 8;
      return (err < 0) ? -r : r;
   endfunction

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic void reset_model();
      lock_cfg.alpha_ext   = ALPHA_EXT_RST;
      lock_cfg.alpha_gen   = ALPHA_GEN_RST;
      lock_cfg.prop_gain   = PROP_GAIN_RST;
      lock_cfg.integ_gain  = INTEG_GAIN_RST;
      lock_cfg.lock_tol    = LOCK_TOL_RST;
      lock_cfg.word_per_hz = WPH_RST;
      lock_cfg.start_word  = START_WORD_RST;
      smoothed_ext     = SMOOTH_RESET;
      smoothed_gen     = SMOOTH_RESET;
      smoothers_seeded = 0;
      integ_acc        = 0;
      tracked_word     = START_WORD_RST;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] value);
      case (idx)
         REG_ALPHA_EXT:   lock_cfg.alpha_ext   = value[GAIN_W-1:0];
         REG_ALPHA_GEN:   lock_cfg.alpha_gen   = value[GAIN_W-1:0];
         REG_PROP_GAIN:   lock_cfg.prop_gain   = value[GAIN_W-1:0];
         REG_INTEG_GAIN:  lock_cfg.integ_gain  = value[GAIN_W-1:0];
         REG_LOCK_TOL:    lock_cfg.lock_tol    = value[GAIN_W-1:0];
         REG_WORD_PER_HZ: lock_cfg.word_per_hz = value[WPH_W-1:0];
         REG_START_WORD: begin
            lock_cfg.start_word = value[FREQ_W-1:0];
            tracked_word        = value[FREQ_W-1:0];
         end
         default: ;  // unmapped index, write dropped
      endcase
   endfunction

   function automatic lock_result_type predict_lock_step(input logic [FREQ_W-1:0] ext,
                                                         input logic [FREQ_W-1:0] gen,
                                                         input logic valid);
      lock_result_type r;
      longint err, step, mag_s, delta;
      err = 0;
      r.word_written = 1'b0;
      if (valid) begin
         if (!smoothers_seeded) begin
            smoothed_ext     = ext;
            smoothed_gen     = gen;
            smoothers_seeded = 1;
         end else begin
            smoothed_ext = smooth_freq(smoothed_ext, ext, lock_cfg.alpha_ext);
            smoothed_gen = smooth_freq(smoothed_gen, gen, lock_cfg.alpha_gen);
         end
         err = longint'(smoothed_ext) - longint'(smoothed_gen);
         if (err > -DEAD_BAND && err < DEAD_BAND) err = 0;
         // integrator dumps on sign reversal, then accumulates
         if ((integ_acc > 0 && err < 0) || (integ_acc < 0 && err > 0)) integ_acc = 0;
         integ_acc = clamp_sym(integ_acc + round_gain(lock_cfg.integ_gain, err), INTEG_CLAMP);
         step = clamp_sym(round_gain(lock_cfg.prop_gain, err) + integ_acc, STEP_CLAMP);
         if (((err < 0) ? -err : err) > longint'(lock_cfg.lock_tol)) begin
            mag_s = (step < 0) ? -step : step;
            delta = (mag_s * longint'(lock_cfg.word_per_hz)) >>> 24;
            if (step < 0) tracked_word = tracked_word - delta[FREQ_W-1:0];
            else tracked_word = tracked_word + delta[FREQ_W-1:0];
            r.word_written = 1'b1;
         end
      end
      r.tuning_word   = tracked_word;
      r.low_reg_word  = {REG_SELECT, tracked_word[13:0]};
      r.high_reg_word = {REG_SELECT, tracked_word[27:14]};
      r.freq_error    = err[ERR_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- request side
   task automatic send_frame(input logic [FREQ_W-1:0] ext, input logic [FREQ_W-1:0] gen,
                             input logic valid, input bit typed, input lock_result_type want);
      lock_result_type predicted;
      req_tdata  <= {gen, ext};
      req_tuser  <= valid;
      req_tvalid <= 1'b1;
      req_held    = 1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_lock_step(ext, gen, valid);
      pending_lock_results.push_back(typed ? want : predicted);
      // bursts of requests, random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         req_held    = 0;
         repeat ($urandom_range(9) == 0 ? $urandom_range(40, 13) : $urandom_range(12, 1))
            @(posedge clock);
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(128, 64) : $urandom_range(24);
      end
   endtask

   // hold requests until every response is back, then let the block settle
   task automatic wait_drained();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held    = 0;
      end
      while (pending_lock_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_frame(input logic [FREQ_W-1:0] ext,
                                     input logic [FREQ_W-1:0] gen, input logic valid);
      stim_row_type row;
      row.kind  = ROW_FRAME;
      row.ext   = ext;
      row.gen   = gen;
      row.valid = valid;
      row.idx   = '0;
      row.value = '0;
      row.typed = 0;
      row.want  = '0;
      directed_rows.push_back(row);
   endfunction

   // frame whose response is known outright: no update, zero error
   function automatic void add_known(input logic [FREQ_W-1:0] ext,
                                     input logic [FREQ_W-1:0] gen, input logic valid,
                                     input logic [FREQ_W-1:0] word,
                                     input logic [15:0] low_word, input logic [15:0] high_word);
      add_frame(ext, gen, valid);
      directed_rows[$].typed = 1;
      directed_rows[$].want  = '{word, 1'b0, low_word, high_word, '0};
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DAT_W-1:0] value);
      add_frame('0, '0, 1'b0);
      directed_rows[$].kind  = ROW_WRITE;
      directed_rows[$].idx   = idx;
      directed_rows[$].value = value;
   endfunction

   function automatic logic [CSR_DAT_W-1:0] phase_value(input int phase,
                                                        input logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DAT_W-1:0] junk;
      junk = CSR_DAT_W'($urandom);
      if (phase == 1) return '0;
      if (phase == 2) return '1;
      if (phase == 0) begin
         case (idx)
            REG_ALPHA_EXT:   return CSR_DAT_W'(ALPHA_EXT_RST);
            REG_ALPHA_GEN:   return CSR_DAT_W'(ALPHA_GEN_RST);
            REG_PROP_GAIN:   return CSR_DAT_W'(PROP_GAIN_RST);
            REG_INTEG_GAIN:  return CSR_DAT_W'(INTEG_GAIN_RST);
            REG_LOCK_TOL:    return CSR_DAT_W'(LOCK_TOL_RST);
            REG_WORD_PER_HZ: return CSR_DAT_W'(WPH_RST);
            default:         return junk;
         endcase
      end
      // random settings; upper bits beyond each register's width carry junk
      case (idx)
         REG_ALPHA_EXT, REG_ALPHA_GEN: begin
            case ($urandom_range(3))
               0:       return {junk[27:16], 16'h0000};
               1:       return {junk[27:16], 16'hFFFF};
               default: return junk;
            endcase
         end
         REG_PROP_GAIN, REG_INTEG_GAIN:
            return {junk[27:16], ($urandom_range(4) == 0) ? junk[15:0]
                                                         : 16'($urandom_range(2048))};
         REG_LOCK_TOL:    return {junk[27:16], 16'($urandom_range(4096))};
         default:         return junk;
      endcase
   endfunction

   function automatic longint random_offset();
      longint mag;
      case ($urandom_range(3))
         0:       mag = $urandom_range(1023);
         1:       mag = $urandom_range(8191);
         2:       mag = $urandom_range(200000);
         default: mag = $urandom_range(FREQ_MAX);
      endcase
      return $urandom_range(1) ? mag : -mag;
   endfunction

   // ---------------------------------------------------------------- response side
   // receiver stalls follow a mode that is chosen anew at random whenever its stretch runs out
   always @(posedge clock) begin
      if (ready_stretch == 0) begin
         ready_mode    <= ready_mode_type'($urandom_range(3));
         ready_stretch <= $urandom_range(256, 32);
      end else begin
         ready_stretch <= ready_stretch - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= $urandom_range(1);
         RDY_SPARSE: rsp_tready <= ($urandom_range(3) == 0);
         default:    rsp_tready <= ready_stretch[3];
      endcase
   end

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      lock_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lock_results.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_lock_results.pop_front();
            check_field("tuning_word", want.tuning_word, rsp_tdata[27:0]);
            check_field("low_reg_word", want.low_reg_word, rsp_tdata[43:28]);
            check_field("high_reg_word", want.high_reg_word, rsp_tdata[59:44]);
            check_field("freq_error", want.freq_error, rsp_tdata[88:60]);
            check_field("tdata padding", 0, rsp_tdata[RSP_DATA_W-1:89]);
            check_field("word_written", want.word_written, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      localparam logic [FREQ_W-1:0] F = 28'd1000000;
      logic [CSR_IDX_W-1:0] reg_order[8];
      logic [FREQ_W-1:0]    base, gen, ext;
      int                   frames;
      reg_order = '{REG_ALPHA_EXT, REG_ALPHA_GEN, REG_PROP_GAIN, REG_INTEG_GAIN,
                    REG_LOCK_TOL, REG_WORD_PER_HZ, REG_START_WORD, REG_UNUSED};
      reset_model();

      // invalid frames straight after reset leave the word at zero
      add_known(FREQ_MAX, '0, 1'b0, '0, 16'h4000, 16'h4000);
      add_known('0, FREQ_MAX, 1'b0, '0, 16'h4000, 16'h4000);
      // seeding frame with equal inputs: zero error, nothing written
      add_known(28'd5555555, 28'd5555555, 1'b1, '0, 16'h4000, 16'h4000);
      // no smoothing from here, word parked at the top
      add_write(REG_ALPHA_EXT, '0);
      add_write(REG_ALPHA_GEN, '0);
      add_write(REG_START_WORD, FREQ_MAX);
      add_known(F, F, 1'b0, FREQ_MAX, 16'h7FFF, 16'h7FFF);
      // edges of the dead zone
      add_known(F + 511, F, 1'b1, FREQ_MAX, 16'h7FFF, 16'h7FFF);
      add_known(F, F + 511, 1'b1, FREQ_MAX, 16'h7FFF, 16'h7FFF);
      add_frame(F + 512, F, 1'b1);                 // first update wraps past the top
      add_frame(F, F + 512, 1'b1);                 // sign reversal dumps the integrator
      // largest errors, integrator and step run into their clamps
      repeat (4) add_frame(FREQ_MAX, '0, 1'b1);
      repeat (3) add_frame('0, FREQ_MAX, 1'b1);
      // largest gains and scale, tolerance at its top
      add_write(REG_PROP_GAIN, FREQ_MAX);
      add_write(REG_INTEG_GAIN, FREQ_MAX);
      add_write(REG_WORD_PER_HZ, FREQ_MAX);
      add_write(REG_LOCK_TOL, FREQ_MAX);
      add_frame(F + 65535, F, 1'b1);               // at tolerance: integrator only
      add_frame(F + 65536, F, 1'b1);
      add_frame(F, F + 65536, 1'b1);
      add_write(REG_LOCK_TOL, '0);
      add_write(REG_UNUSED, FREQ_MAX);             // dropped by the block
      add_frame(F + 512, F, 1'b1);
      add_frame(F, F, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_drained();
            write_register(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_frame(directed_rows[i].ext, directed_rows[i].gen, directed_rows[i].valid,
                       directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random phases, each under its own setting; the block drains in between
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         foreach (reg_order[r]) write_register(reg_order[r], phase_value(phase, reg_order[r]));
         base   = ($urandom_range(3) == 0) ? FREQ_W'($urandom) : FREQ_W'($urandom_range(51200000));
         frames = 0;
         while (frames < PHASE_FRAMES) begin
            case ($urandom_range(99)) inside
               [0:7]: begin
                  send_frame(FREQ_W'($urandom), FREQ_W'($urandom), 1'b0, 0, '0);
               end
               [8:12]: begin
                  send_frame(FREQ_W'($urandom), FREQ_W'($urandom), 1'b1, 0, '0);
                  frames++;
               end
               default: begin
                  // tracking sequence: generator near the base, external near the generator
                  if ($urandom_range(15) == 0) base = FREQ_W'(longint'(base) + random_offset());
                  gen = FREQ_W'(longint'(base) + $urandom_range(600) - 300);
                  ext = ($urandom_range(2) == 0) ? FREQ_W'(longint'(gen) + random_offset())
                                                 : FREQ_W'(longint'(gen) + $urandom_range(2048) - 1024);
                  send_frame(ext, gen, 1'b1, 0, '0);
                  frames++;
               end
            endcase
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
